// ===== rtl/fqs_pkg.sv =====
// fqs_pkg: sizes, operation codes and status codes for the FIFO queue with search.
// Used by fifo_queue_with_search_top; depends on nothing else.
package fqs_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // operation field
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_SEARCH  = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   // status field
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      count_type;

   // ring index advance with wrap at the last slot
   function automatic addr_type next_index(input addr_type i);
      addr_type r;
      if (i == addr_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + addr_type'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/fifo_queue_with_search_top.sv =====
// Ring-buffer FIFO of data words with enqueue, dequeue, linear search and clear.
// Enqueue and clear: result strobe registered in the cycle after start; busy stays low.
// Dequeue (non-empty): registered memory read in S_DEQ, then registered result; busy in S_DEQ.
// Search: one compare per cycle through the shared comparator, walking from head
// until a match or the last occupied slot; the result is registered. The result is never stalled.
// Synchronous active-high reset empties the queue; stored words are not cleared.
module fifo_queue_with_search_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_position,
   output logic signed [31:0] rsp_removed_value,
   output logic [4:0]         rsp_occupancy,
   output logic               rsp_is_empty
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DEQ    = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;

   logic [1:0]          state_ff, state_in;
   fqs_pkg::addr_type   head_ff, head_in;
   fqs_pkg::addr_type   tail_ff, tail_in;
   fqs_pkg::count_type  count_ff, count_in;
   fqs_pkg::addr_type   k_ff, k_in;
   fqs_pkg::addr_type   idx_ff, idx_in;
   fqs_pkg::word_type   value_ff, value_in;

   fqs_pkg::word_type   mem_ff [fqs_pkg::DEPTH];
   fqs_pkg::word_type   rdata_ff;
   fqs_pkg::addr_type   rd_addr;
   logic                wr_en;
   fqs_pkg::word_type   req_word;
   logic                accept;
   logic                is_full;
   logic                match;
   logic                last_pos;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff, status_in;
   logic [3:0]          position_ff, position_in;
   logic signed [31:0]  removed_ff, removed_in;
   logic [4:0]          occ_ff, occ_in;
   logic                empty_ff, empty_in;

   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign req_word = fqs_pkg::word_type'($unsigned(req_value));
   assign is_full  = (count_ff == fqs_pkg::count_type'(fqs_pkg::DEPTH));
   // shared comparator: stored word against the search key
   assign match    = (rdata_ff == value_ff);
   assign last_pos = ((fqs_pkg::count_type'(k_ff) + fqs_pkg::count_type'(1)) == count_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      wr_en        = 1'b0;
      rd_addr      = head_ff;
      rsp_valid_in = 1'b0;
      status_in    = fqs_pkg::ST_OK;
      position_in  = '0;
      removed_in   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_operation)
                  fqs_pkg::OP_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        status_in = fqs_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = fqs_pkg::next_index(tail_ff);
                        count_in = count_ff + fqs_pkg::count_type'(1);
                     end
                  end
                  fqs_pkg::OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = fqs_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_DEQ;
                     end
                  end
                  fqs_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = fqs_pkg::ST_EMPTY;
                     end else begin
                        // head word is read now; issue one address ahead from here on
                        value_in = req_word;
                        k_in     = '0;
                        idx_in   = fqs_pkg::next_index(head_ff);
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        status_in = fqs_pkg::ST_EMPTY;
                     end
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
               endcase
            end
         end
         S_DEQ: begin
            rsp_valid_in = 1'b1;
            removed_in   = 32'($signed(rdata_ff));
            head_in      = fqs_pkg::next_index(head_ff);
            count_in     = count_ff - fqs_pkg::count_type'(1);
            state_in     = S_IDLE;
         end
         S_SEARCH: begin
            rd_addr = idx_ff;
            if (match) begin
               rsp_valid_in = 1'b1;
               position_in  = 4'(k_ff);
               state_in     = S_IDLE;
            end else if (last_pos) begin
               rsp_valid_in = 1'b1;
               status_in    = fqs_pkg::ST_NOT_FOUND;
               state_in     = S_IDLE;
            end else begin
               k_in   = k_ff + fqs_pkg::addr_type'(1);
               idx_in = fqs_pkg::next_index(idx_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      occ_in   = 5'(count_in);
      empty_in = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[tail_ff] <= req_word;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      idx_ff      <= idx_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      position_ff <= position_in;
      removed_ff  <= removed_in;
      occ_ff      <= occ_in;
      empty_ff    <= empty_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_position      = position_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_occupancy     = occ_ff;
   assign rsp_is_empty      = empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fqs_pkg::count_type'(fqs_pkg::DEPTH))
      else $error("occupancy above depth");

   a_ring_align: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == fqs_pkg::count_type'(fqs_pkg::DEPTH))
         |-> head_ff == tail_ff)
      else $error("head and tail disagree with occupancy");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |-> fqs_pkg::count_type'(k_ff) < count_ff)
      else $error("search walked past the tail");

   a_long_op_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && count_ff != '0 &&
       (req_operation == fqs_pkg::OP_DEQUEUE || req_operation == fqs_pkg::OP_SEARCH))
         |=> busy && !rsp_valid)
      else $error("dequeue or search finished without a memory read");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_occupancy == 5'd0))
      else $error("empty flag disagrees with occupancy");

endmodule
